// File: src/nv_pkg.sv
// Package for the 3-D vector normalizer: stage counts and the payload
// structs carried between the pipeline cells. No dependencies.
package nv_pkg;

  localparam int unsigned LANES      = 3;
  localparam int unsigned DIV_STEPS  = 60;
  localparam int unsigned SQRT_STEPS = 31;
  // Stages: magnitude, square, sum, first division step, division cells,
  // square-root cells, output register.
  localparam int unsigned FRONT_STG  = 4;
  localparam int unsigned SQRT_BASE  = FRONT_STG + DIV_STEPS;
  localparam int unsigned OUT_STG    = SQRT_BASE + SQRT_STEPS;
  localparam int unsigned NUM_STG    = OUT_STG + 1;

  typedef struct packed {
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic [31:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] x_unit;
    logic [31:0] y_unit;
    logic [31:0] z_unit;
    logic        zero_vector;
  } out_item_t;

  // Work of one division cell: partial remainders and quotients per lane.
  typedef struct packed {
    logic [LANES-1:0][63:0] rem;
    logic [LANES-1:0][60:0] quo;
    logic [63:0]            den;
    logic [LANES-1:0]       neg;
    logic                   zero;
  } div_t;

  // Work of one square-root cell: radicand bits still to consume, root so
  // far and remainder per lane.
  typedef struct packed {
    logic [LANES-1:0][61:0] src;
    logic [LANES-1:0][30:0] root;
    logic [LANES-1:0][32:0] rem;
    logic [LANES-1:0]       neg;
    logic                   zero;
  } sqrt_t;

endpackage

// File: src/nv_if.sv
// Valid/ready channel interfaces for the vector normalizer.
// Depends on nv_pkg for nothing but shares its field widths.
interface nv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;
  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface nv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_unit;
  logic [31:0] y_unit;
  logic [31:0] z_unit;
  logic        zero_vector;
  modport source (output valid, x_unit, y_unit, z_unit, zero_vector, input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, zero_vector, output ready);
endinterface

// File: src/nv_div_cell.sv
// One restoring-division cell: one quotient bit for each of the three lanes.
// Depends on nv_pkg.
module nv_div_cell import nv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic vld_i,
  input  div_t d_i,
  output logic vld_o,
  output div_t d_o
);

  logic vld_r;
  div_t d_r;
  div_t d_nxt;

  always_comb begin
    logic [64:0] t;
    logic        ge;
    d_nxt = d_i;
    for (int l = 0; l < LANES; l++) begin
      t  = {d_i.rem[l], 1'b0};
      ge = t >= {1'b0, d_i.den};
      d_nxt.rem[l] = ge ? 64'(t - {1'b0, d_i.den}) : t[63:0];
      d_nxt.quo[l] = {d_i.quo[l][59:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// File: src/nv_sqrt_cell.sv
// One integer square-root cell: takes two radicand bits and yields one root
// bit for each lane. Depends on nv_pkg.
module nv_sqrt_cell import nv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  logic  vld_i,
  input  sqrt_t d_i,
  output logic  vld_o,
  output sqrt_t d_o
);

  logic  vld_r;
  sqrt_t d_r;
  sqrt_t d_nxt;

  always_comb begin
    logic [34:0] t;
    logic [32:0] trial;
    logic        ge;
    d_nxt = d_i;
    for (int l = 0; l < LANES; l++) begin
      t     = {d_i.rem[l], d_i.src[l][61:60]};
      trial = {d_i.root[l], 2'b01};
      ge    = t >= {2'b00, trial};
      d_nxt.rem[l]  = ge ? 33'(t - {2'b00, trial}) : t[32:0];
      d_nxt.root[l] = {d_i.root[l][29:0], ge};
      d_nxt.src[l]  = {d_i.src[l][59:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// File: src/vector_normalize_3d.sv
// Top level of the 3-D vector normalizer: front stages, the division and
// square-root cell chains, and the output register.
// Depends on nv_pkg, nv_if, nv_div_cell and nv_sqrt_cell.
//
// Usage:
//   in_ch carries one vector (x_in, y_in, z_in) per item, out_ch one result
//   (x_unit, y_unit, z_unit in Q1.30, zero_vector). Both are valid/ready.
//   Each component c becomes sign(c) * floor(sqrt(c^2 * 2^60 / S)) with
//   S = x^2 + y^2 + z^2; an all-zero vector gives zero fields and
//   zero_vector set.
//   There are 96 register stages: four front stages (magnitude, square,
//   sum, first quotient bit), 60 division cells that each produce one
//   quotient bit, 31 square-root cells that each produce one root bit, and
//   the output register.
//   Throughput is one item per cycle while the receiver does not stall;
//   every stage is a register. Each stage loads when it is empty or its
//   successor loads, so when the receiver stalls the pipeline keeps taking
//   items until its bubbles are filled, then in_ch.ready drops. Up to 96 items are held.
//   Reset clears every stage's valid bit; nothing else needs clearing.
module vector_normalize_3d import nv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nv_in_if.sink       in_ch,
  nv_out_if.source    out_ch
);

  logic [NUM_STG:0]   adv;
  logic [NUM_STG-1:0] vld;

  // Stage 0: magnitudes and signs.
  logic [LANES-1:0][31:0] mag_r;
  logic [LANES-1:0]       neg0_r;
  logic                   v0_r;
  // Stage 1: squares.
  logic [LANES-1:0][63:0] sq1_r;
  logic [LANES-1:0]       neg1_r;
  logic                   v1_r;
  // Stage 2: sum of squares.
  logic [LANES-1:0][63:0] sq2_r;
  logic [63:0]            sum2_r;
  logic [LANES-1:0]       neg2_r;
  logic                   v2_r;
  // Stage 3: first quotient bit.
  div_t                   d3_r;
  logic                   v3_r;

  logic [LANES-1:0][31:0] raw;
  assign raw[0] = in_ch.x_in;
  assign raw[1] = in_ch.y_in;
  assign raw[2] = in_ch.z_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv[0]) v0_r <= in_ch.valid;
      if (adv[1]) v1_r <= v0_r;
      if (adv[2]) v2_r <= v1_r;
      if (adv[3]) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < LANES; l++) begin
        neg0_r[l] <= raw[l][31];
        mag_r[l]  <= raw[l][31] ? 32'(-raw[l]) : raw[l];
      end
    end
    if (adv[1]) begin
      for (int l = 0; l < LANES; l++) begin
        sq1_r[l] <= 64'(mag_r[l]) * 64'(mag_r[l]);
      end
      neg1_r <= neg0_r;
    end
    if (adv[2]) begin
      sq2_r  <= sq1_r;
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      neg2_r <= neg1_r;
    end
    if (adv[3]) begin
      for (int l = 0; l < LANES; l++) begin
        // The square never exceeds the sum, so the top quotient bit is a
        // single compare.
        d3_r.rem[l] <= (sq2_r[l] >= sum2_r) ? 64'(sq2_r[l] - sum2_r) : sq2_r[l];
        d3_r.quo[l] <= 61'(sq2_r[l] >= sum2_r);
      end
      d3_r.den  <= sum2_r;
      d3_r.neg  <= neg2_r;
      d3_r.zero <= (sum2_r == 64'd0);
    end
  end

  assign vld[0] = v0_r;
  assign vld[1] = v1_r;
  assign vld[2] = v2_r;
  assign vld[3] = v3_r;

  // Division chain.
  div_t             dd [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv;
  assign dd[0] = d3_r;
  assign dv[0] = v3_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    nv_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (adv[FRONT_STG+i]),
      .vld_i (dv[i]),
      .d_i   (dd[i]),
      .vld_o (dv[i+1]),
      .d_o   (dd[i+1])
    );
    assign vld[FRONT_STG+i] = dv[i+1];
  end

  // Square-root chain; the 61-bit quotient is padded to an even width.
  sqrt_t               sd [SQRT_STEPS+1];
  sqrt_t               sd0;
  logic [SQRT_STEPS:0] sv;

  always_comb begin
    sd0 = '0;
    for (int l = 0; l < LANES; l++) begin
      sd0.src[l] = {1'b0, dd[DIV_STEPS].quo[l]};
    end
    sd0.neg  = dd[DIV_STEPS].neg;
    sd0.zero = dd[DIV_STEPS].zero;
  end
  assign sd[0] = sd0;
  assign sv[0] = dv[DIV_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    nv_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (adv[SQRT_BASE+i]),
      .vld_i (sv[i]),
      .d_i   (sd[i]),
      .vld_o (sv[i+1]),
      .d_o   (sd[i+1])
    );
    assign vld[SQRT_BASE+i] = sv[i+1];
  end

  // Output register.
  out_item_t              out_r;
  logic                   vout_r;
  logic [LANES-1:0][31:0] res;

  always_comb begin
    logic [31:0] m;
    for (int l = 0; l < LANES; l++) begin
      m      = {1'b0, sd[SQRT_STEPS].root[l]};
      res[l] = sd[SQRT_STEPS].zero ? 32'd0 : (sd[SQRT_STEPS].neg[l] ? 32'(-m) : m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv[OUT_STG]) begin
      vout_r <= sv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      out_r.x_unit      <= res[0];
      out_r.y_unit      <= res[1];
      out_r.z_unit      <= res[2];
      out_r.zero_vector <= sd[SQRT_STEPS].zero;
    end
  end

  assign vld[OUT_STG] = vout_r;

  // A stage loads when it is empty or the stage after it loads.
  always_comb begin
    adv[NUM_STG] = out_ch.ready;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ch.ready        = adv[0];
  assign out_ch.valid       = vout_r;
  assign out_ch.x_unit      = out_r.x_unit;
  assign out_ch.y_unit      = out_r.y_unit;
  assign out_ch.z_unit      = out_r.z_unit;
  assign out_ch.zero_vector = out_r.zero_vector;

endmodule

// File: src/nv_checker.sv
// Port-level checks for the vector normalizer and their bind to the top.
// Depends on vector_normalize_3d and nv_if.
module nv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] x_unit,
  input logic [31:0] y_unit,
  input logic [31:0] z_unit,
  input logic        zero_vector
);

  // A held result must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({x_unit, y_unit, z_unit, zero_vector}))
    else $error("result changed while stalled");

  // With nothing waiting at the output, the pipeline has room.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_vector |-> x_unit == 32'd0 && y_unit == 32'd0 && z_unit == 32'd0)
    else $error("zero vector with nonzero fields");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(x_unit) <= 32'sd1073741824 && $signed(x_unit) >= -32'sd1073741824
                && $signed(y_unit) <= 32'sd1073741824 && $signed(y_unit) >= -32'sd1073741824
                && $signed(z_unit) <= 32'sd1073741824 && $signed(z_unit) >= -32'sd1073741824))
    else $error("unit component out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind vector_normalize_3d nv_checker u_nv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .x_unit      (out_ch.x_unit),
  .y_unit      (out_ch.y_unit),
  .z_unit      (out_ch.z_unit),
  .zero_vector (out_ch.zero_vector)
);

// File: tb/sv/nv_tb_if.sv
`timescale 1ns / 1ps
// Testbench side of the channel interfaces. The testbench uses nv_in_if and
// nv_out_if as defined with the RTL in src/nv_if.sv, so nothing is defined here.

// File: tb/sv/vector_normalize_3d_tb.sv
`timescale 1ns / 1ps
// Testbench for vector_normalize_3d: drives directed and random vectors
// under several idling phases and checks each result against a predictor.
// Depends on nv_pkg, the channel interfaces and the RTL of the block.
module vector_normalize_3d_tb;
  import nv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nv_in_if  in_ch ();
  nv_out_if out_ch ();

  vector_normalize_3d u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_vecs[$];
  out_item_t expected_units[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        error_count = 0;
  int        result_count = 0;
  int        zero_count = 0;
  logic      in_taken = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem = n;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t unit_vector(in_item_t v);
    out_item_t   r;
    logic [31:0] comp[3];
    logic [63:0] mag[3];
    logic [63:0] sq[3];
    logic [63:0] sum;
    logic [127:0] quo;
    logic [31:0] u[3];
    comp[0] = v.x_in;
    comp[1] = v.y_in;
    comp[2] = v.z_in;
    sum = 64'd0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? (64'd1 << 32) - {32'd0, comp[i]} : {32'd0, comp[i]};
      sq[i] = mag[i] * mag[i];
      sum = sum + sq[i];
    end
    r = '0;
    if (sum == 64'd0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      quo = ({64'd0, sq[i]} << 60) / {64'd0, sum};
      u[i] = 32'(int_sqrt(quo[63:0]));
      if (comp[i][31]) u[i] = -u[i];
    end
    r.x_unit = u[0];
    r.y_unit = u[1];
    r.z_unit = u[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    error_count++;
  endtask

  // Records whether the item on the input channel was taken at this edge.
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // Driver: valid stays high across back-to-back items.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_vecs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_t v;
        v = pending_vecs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.x_in <= v.x_in;
        in_ch.y_in <= v.y_in;
        in_ch.z_in <= v.z_in;
        expected_units.push_back(unit_vector(v));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The driver settles the next item at the falling edge, so an item pushed
  // there is always ahead of its result.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_item_t want;
      if (expected_units.size() == 0) begin
        $display("result arrived with no vector outstanding");
        error_count++;
      end else begin
        want = expected_units.pop_front();
        result_count++;
        if (want.zero_vector) zero_count++;
        if (out_ch.x_unit !== want.x_unit) report_mismatch("x_unit", out_ch.x_unit, want.x_unit);
        if (out_ch.y_unit !== want.y_unit) report_mismatch("y_unit", out_ch.y_unit, want.y_unit);
        if (out_ch.z_unit !== want.z_unit) report_mismatch("z_unit", out_ch.z_unit, want.z_unit);
        if (out_ch.zero_vector !== want.zero_vector)
          report_mismatch("zero_vector", {31'd0, out_ch.zero_vector},
                          {31'd0, want.zero_vector});
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7) - 3;
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t v;
    v.x_in = x;
    v.y_in = y;
    v.z_in = z;
    pending_vecs.push_back(v);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) add_vec(0, 0, 0);
      else add_vec(rand_comp(), rand_comp(), rand_comp());
    end
    while (pending_vecs.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    in_ch.z_in = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: zero vector, single axes, full-scale negatives, extremes.
    add_vec(0, 0, 0);
    add_vec(32'd1, 0, 0);
    add_vec(0, 32'hffff_ffff, 0);
    add_vec(0, 0, 32'h8000_0000);
    add_vec(32'h8000_0000, 0, 0);
    add_vec(32'h7fff_ffff, 0, 0);
    add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_vec(32'h8000_0000, 32'h7fff_ffff, 32'd1);
    add_vec(32'd1, 32'd1, 32'd1);
    add_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_vec(32'd3, 32'd4, 0);
    add_vec(32'd1, 32'h8000_0000, 0);
    add_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000);
    add_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff);
    run_phase(0, 0, 100);
    run_phase(82, 0, 80);
    run_phase(0, 82, 80);
    run_phase(30, 30, 80);
    run_phase(0, 0, 60);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d results (%0d zero vectors) over directed and random vectors",
             result_count, zero_count);
    $display("under free-running, sender-idle, receiver-stall and mixed phases.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
src/nv_pkg.sv
src/nv_if.sv
src/nv_div_cell.sv
src/nv_sqrt_cell.sv
src/vector_normalize_3d.sv
src/nv_checker.sv
tb/sv/nv_tb_if.sv
tb/sv/vector_normalize_3d_tb.sv
